// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the color box median locator RTL.
// Depends on clk and rst_n being visible where the macros are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion violated");

// Consequent that must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion violated");

// Consequent that must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion violated");

`endif

// ===== rtl/cbml_pkg.sv =====
// Package for the color box median locator: types, register map and defaults.
// Used by every module of the block; depends on nothing.
`default_nettype none

package cbml_pkg;

  localparam int CAPACITY_DEF   = 1024;
  localparam int COORD_BITS_DEF = 13;
  localparam int CHAN_BITS      = 8;
  localparam int TOTAL_BITS     = 11;
  localparam int NUM_REGS       = 6;
  localparam int CFG_IDX_BITS   = 3;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_BLUE_LOW   = 3'd0,
    REG_GREEN_LOW  = 3'd1,
    REG_RED_LOW    = 3'd2,
    REG_BLUE_HIGH  = 3'd3,
    REG_GREEN_HIGH = 3'd4,
    REG_RED_HIGH   = 3'd5
  } reg_idx_t;

  localparam logic [CHAN_BITS-1:0] BOX_RESET [NUM_REGS] = '{
    8'd50, 8'd122, 8'd230, 8'd160, 8'd244, 8'd255
  };

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_SHIFT  = 2'd2
  } cell_op_t;

  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_DRAIN = 1'b1
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/color_box_median_locator_top.sv =====
// A pixel without the last mark is taken at once; one pixel per cycle while busy is low.
// A last pixel raises busy while the cell chain shifts left until the median sits
// in cell 0 and the result is registered; the result strobe comes in the cycle after.
// Results cannot be stalled. Synchronous active-low reset clears the count, the drop
// flag and the box registers to the default orange box; cell contents are not reset.
`default_nettype none

module color_box_median_locator_top
  import cbml_pkg::*;
#(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    start,
  output logic                   busy,
  input  wire [CHAN_BITS-1:0]    in_blue,
  input  wire [CHAN_BITS-1:0]    in_green,
  input  wire [CHAN_BITS-1:0]    in_red,
  input  wire [COORD_BITS-1:0]   in_row,
  input  wire [COORD_BITS-1:0]   in_col,
  input  wire                    in_last,
  output logic                   out_valid,
  output logic [COORD_BITS-1:0]  out_median_row,
  output logic [COORD_BITS-1:0]  out_median_col,
  output logic [TOTAL_BITS-1:0]  out_match_total,
  output logic                   out_empty_res,
  output logic                   out_overflow,
  input  wire                    cfg_valid,
  output logic                   cfg_ready,
  input  wire [CFG_IDX_BITS-1:0] cfg_index,
  input  wire [CHAN_BITS-1:0]    cfg_data
);

  `include "assert_macros.svh"

  localparam int CNT_W = $clog2(CAPACITY + 1);

  state_t                state_r, state_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [CNT_W-1:0]      rem_r, rem_nxt;
  logic                  drop_r, drop_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [COORD_BITS-1:0] med_row_r, med_row_nxt;
  logic [COORD_BITS-1:0] med_col_r, med_col_nxt;
  logic [TOTAL_BITS-1:0] total_r, total_nxt;
  logic                  empty_r, empty_nxt;
  logic                  ovf_r, ovf_nxt;
  cell_op_t              op;
  logic                  match;
  logic                  accept;
  logic                  full;

  logic [COORD_BITS-1:0] row_q  [CAPACITY];
  logic [COORD_BITS-1:0] col_q  [CAPACITY];
  logic                  gt_row [CAPACITY];
  logic                  gt_col [CAPACITY];

  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign full      = (cnt_r == CNT_W'(CAPACITY));

  cbml_box u_box (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .blue      (in_blue),
    .green     (in_green),
    .red       (in_red),
    .match     (match)
  );

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [COORD_BITS-1:0] l_row, l_col, r_row, r_col;
    logic                  l_gt_row, l_gt_col;

    if (i == 0) begin : g_first
      assign l_row    = '0;
      assign l_col    = '0;
      assign l_gt_row = 1'b0;
      assign l_gt_col = 1'b0;
    end else begin : g_mid
      assign l_row    = row_q[i-1];
      assign l_col    = col_q[i-1];
      assign l_gt_row = gt_row[i-1];
      assign l_gt_col = gt_col[i-1];
    end

    if (i == CAPACITY - 1) begin : g_end
      assign r_row = '0;
      assign r_col = '0;
    end else begin : g_inner
      assign r_row = row_q[i+1];
      assign r_col = col_q[i+1];
    end

    cbml_cell #(
      .IDX        (i),
      .COORD_BITS (COORD_BITS),
      .CNT_W      (CNT_W)
    ) u_cell (
      .clk         (clk),
      .op          (op),
      .cnt         (cnt_r),
      .ins_row     (in_row),
      .ins_col     (in_col),
      .left_row    (l_row),
      .left_col    (l_col),
      .left_gt_row (l_gt_row),
      .left_gt_col (l_gt_col),
      .right_row   (r_row),
      .right_col   (r_col),
      .row_q       (row_q[i]),
      .col_q       (col_q[i]),
      .gt_row      (gt_row[i]),
      .gt_col      (gt_col[i])
    );
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    rem_nxt       = rem_r;
    drop_nxt      = drop_r;
    out_valid_nxt = 1'b0;
    med_row_nxt   = med_row_r;
    med_col_nxt   = med_col_r;
    total_nxt     = total_r;
    empty_nxt     = empty_r;
    ovf_nxt       = ovf_r;
    op            = CELL_HOLD;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (match && !full) begin
            op      = CELL_INSERT;
            cnt_nxt = cnt_r + CNT_W'(1);
          end
          if (match && full) begin
            drop_nxt = 1'b1;
          end
          if (in_last) begin
            rem_nxt   = cnt_nxt >> 1;
            state_nxt = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (rem_r != '0) begin
          op      = CELL_SHIFT;
          rem_nxt = rem_r - CNT_W'(1);
        end else begin
          out_valid_nxt = 1'b1;
          empty_nxt     = (cnt_r == '0);
          med_row_nxt   = (cnt_r == '0) ? '0 : row_q[0];
          med_col_nxt   = (cnt_r == '0) ? '0 : col_q[0];
          total_nxt     = TOTAL_BITS'(cnt_r);
          ovf_nxt       = drop_r;
          cnt_nxt       = '0;
          drop_nxt      = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      rem_r       <= '0;
      drop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rem_r       <= rem_nxt;
      drop_r      <= drop_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    med_row_r <= med_row_nxt;
    med_col_r <= med_col_nxt;
    total_r   <= total_nxt;
    empty_r   <= empty_nxt;
    ovf_r     <= ovf_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_median_row  = med_row_r;
  assign out_median_col  = med_col_r;
  assign out_match_total = total_r;
  assign out_empty_res   = empty_r;
  assign out_overflow    = ovf_r;

  `ASSERT_ALWAYS(a_cnt_bound, cnt_r <= CNT_W'(CAPACITY))
  `ASSERT_IMPL(a_beat_after_drain, out_valid_r, $past(state_r) == ST_DRAIN)
  `ASSERT_IMPL(a_frame_cleared, out_valid_r, (cnt_r == '0) && !drop_r && !busy)
  `ASSERT_IMPL(a_sorted_head, (state_r == ST_IDLE) && (cnt_r >= CNT_W'(2)),
               (row_q[0] <= row_q[1]) && (col_q[0] <= col_q[1]))
  `ASSERT_NEXT(a_last_busy, accept && in_last, busy)

endmodule

`default_nettype wire

// ===== rtl/cbml_cell.sv =====
// One cell of the sorted chain: holds one row and one column entry.
// Depends on cbml_pkg; neighbors exchange values and compare flags each cycle.
`default_nettype none

module cbml_cell
  import cbml_pkg::*;
#(
  parameter int IDX        = 0,
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int CNT_W      = 11
) (
  input  wire                   clk,
  input  cell_op_t              op,
  input  wire [CNT_W-1:0]       cnt,
  input  wire [COORD_BITS-1:0]  ins_row,
  input  wire [COORD_BITS-1:0]  ins_col,
  input  wire [COORD_BITS-1:0]  left_row,
  input  wire [COORD_BITS-1:0]  left_col,
  input  wire                   left_gt_row,
  input  wire                   left_gt_col,
  input  wire [COORD_BITS-1:0]  right_row,
  input  wire [COORD_BITS-1:0]  right_col,
  output logic [COORD_BITS-1:0] row_q,
  output logic [COORD_BITS-1:0] col_q,
  output logic                  gt_row,
  output logic                  gt_col
);

  logic [COORD_BITS-1:0] row_r, row_nxt;
  logic [COORD_BITS-1:0] col_r, col_nxt;
  logic                  occ;

  // An unoccupied cell counts as greater, so the first free cell takes the new value.
  assign occ    = CNT_W'(IDX) < cnt;
  assign gt_row = !occ || (row_r > ins_row);
  assign gt_col = !occ || (col_r > ins_col);
  assign row_q  = row_r;
  assign col_q  = col_r;

  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    case (op)
      CELL_INSERT: begin
        if (gt_row) begin
          row_nxt = left_gt_row ? left_row : ins_row;
        end
        if (gt_col) begin
          col_nxt = left_gt_col ? left_col : ins_col;
        end
      end
      CELL_SHIFT: begin
        row_nxt = right_row;
        col_nxt = right_col;
      end
      default: begin
        row_nxt = row_r;
        col_nxt = col_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    row_r <= row_nxt;
    col_r <= col_nxt;
  end

endmodule

`default_nettype wire

// ===== rtl/cbml_box.sv =====
// Color box registers and the pixel match test against them.
// Depends on cbml_pkg for the register map and reset values.
`default_nettype none

module cbml_box
  import cbml_pkg::*;
(
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    cfg_we,
  input  wire [CFG_IDX_BITS-1:0] cfg_index,
  input  wire [CHAN_BITS-1:0]    cfg_data,
  input  wire [CHAN_BITS-1:0]    blue,
  input  wire [CHAN_BITS-1:0]    green,
  input  wire [CHAN_BITS-1:0]    red,
  output logic                   match
);

  logic [CHAN_BITS-1:0] box_r [NUM_REGS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        box_r[i] <= BOX_RESET[i];
      end
    end else if (cfg_we && (cfg_index <= REG_RED_HIGH)) begin
      box_r[cfg_index] <= cfg_data;
    end
  end

  assign match = (blue  >= box_r[REG_BLUE_LOW])  && (blue  <= box_r[REG_BLUE_HIGH])  &&
                 (green >= box_r[REG_GREEN_LOW]) && (green <= box_r[REG_GREEN_HIGH]) &&
                 (red   >= box_r[REG_RED_LOW])   && (red   <= box_r[REG_RED_HIGH]);

endmodule

`default_nettype wire

// ===== tb/cbml_median_checker.sv =====
// Checker for the color box median locator: it watches the pixel, result and register channels.
// It keeps its own box registers and sorted coordinate stores, and compares every result beat.
// Depends on cbml_pkg for widths, register indexes and the reset box.
`timescale 1ns / 1ps

module cbml_median_checker
  import cbml_pkg::*;
#(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    start,
  input  wire                    busy,
  input  wire [CHAN_BITS-1:0]    in_blue,
  input  wire [CHAN_BITS-1:0]    in_green,
  input  wire [CHAN_BITS-1:0]    in_red,
  input  wire [COORD_BITS-1:0]   in_row,
  input  wire [COORD_BITS-1:0]   in_col,
  input  wire                    in_last,
  input  wire                    out_valid,
  input  wire [COORD_BITS-1:0]   out_median_row,
  input  wire [COORD_BITS-1:0]   out_median_col,
  input  wire [TOTAL_BITS-1:0]   out_match_total,
  input  wire                    out_empty_res,
  input  wire                    out_overflow,
  input  wire                    cfg_valid,
  input  wire                    cfg_ready,
  input  wire [CFG_IDX_BITS-1:0] cfg_index,
  input  wire [CHAN_BITS-1:0]    cfg_data,
  output int                     fail_count,
  output int                     pending
);

  localparam int AXIS_ROW = 0;
  localparam int AXIS_COL = 1;

  typedef struct {
    logic [COORD_BITS-1:0] median_row;
    logic [COORD_BITS-1:0] median_col;
    logic [TOTAL_BITS-1:0] match_total;
    logic                  empty_res;
    logic                  overflow;
  } frame_summary_t;

  logic [CHAN_BITS-1:0]  box [NUM_REGS];
  logic [COORD_BITS-1:0] sorted_coord [2][CAPACITY];
  int                    stored;
  logic                  dropped;
  frame_summary_t        expected_summaries [$];

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("[%0t] %s mismatch: got %0d, expected %0d", $time, field, got, want);
    fail_count++;
  endtask

  function automatic logic chan_in_box(input logic [CHAN_BITS-1:0] v, input reg_idx_t lo,
                                       input reg_idx_t hi);
    return (v >= box[lo]) && (v <= box[hi]);
  endfunction

  task automatic insert_coord(input int axis, input logic [COORD_BITS-1:0] v);
    int k;
    k = stored;
    while (k > 0 && sorted_coord[axis][k-1] > v) begin
      sorted_coord[axis][k] = sorted_coord[axis][k-1];
      k--;
    end
    sorted_coord[axis][k] = v;
  endtask

  task automatic absorb_pixel();
    frame_summary_t s;
    if (chan_in_box(in_blue, REG_BLUE_LOW, REG_BLUE_HIGH) &&
        chan_in_box(in_green, REG_GREEN_LOW, REG_GREEN_HIGH) &&
        chan_in_box(in_red, REG_RED_LOW, REG_RED_HIGH)) begin
      if (stored < CAPACITY) begin
        insert_coord(AXIS_ROW, in_row);
        insert_coord(AXIS_COL, in_col);
        stored++;
      end else begin
        dropped = 1'b1;
      end
    end
    if (in_last) begin
      s.empty_res   = (stored == 0);
      s.median_row  = (stored == 0) ? '0 : sorted_coord[AXIS_ROW][stored / 2];
      s.median_col  = (stored == 0) ? '0 : sorted_coord[AXIS_COL][stored / 2];
      s.match_total = TOTAL_BITS'(stored);
      s.overflow    = dropped;
      expected_summaries.insert(expected_summaries.size(), s);
      stored  = 0;
      dropped = 1'b0;
    end
  endtask

  task automatic compare_summary();
    frame_summary_t s;
    if (expected_summaries.size() == 0) begin
      report_mismatch("unexpected result beat, out_valid", 1, 0);
    end else begin
      s = expected_summaries.pop_front();
      if (out_median_row !== s.median_row)
        report_mismatch("median_row", out_median_row, s.median_row);
      if (out_median_col !== s.median_col)
        report_mismatch("median_col", out_median_col, s.median_col);
      if (out_match_total !== s.match_total)
        report_mismatch("match_total", out_match_total, s.match_total);
      if (out_empty_res !== s.empty_res)
        report_mismatch("empty_res", out_empty_res, s.empty_res);
      if (out_overflow !== s.overflow)
        report_mismatch("overflow", out_overflow, s.overflow);
    end
  endtask

  always @(posedge clk) begin : sample
    int i;
    if (!rst_n) begin
      for (i = 0; i < NUM_REGS; i++) box[i] = BOX_RESET[i];
      stored     = 0;
      dropped    = 1'b0;
      fail_count = 0;
      expected_summaries.delete();
    end else begin
      if (out_valid) compare_summary();
      if (start && !busy) absorb_pixel();
      if (cfg_valid && cfg_ready && cfg_index < NUM_REGS) box[cfg_index] = cfg_data;
    end
    pending = expected_summaries.size();
  end

endmodule

// ===== tb/color_box_median_locator_top_tb.sv =====
// Testbench top for color_box_median_locator_top: clock, reset, pixel and register stimulus.
// Prediction and comparison live in cbml_median_checker; this module gives the verdict.
// Depends on cbml_pkg, the block and the checker.
`timescale 1ns / 1ps

module color_box_median_locator_top_tb;
  import cbml_pkg::*;

  localparam int COORD_W        = COORD_BITS_DEF;
  localparam int RANDOM_ITEMS   = 340;
  localparam int MIN_FRAMES     = 20;
  localparam int OVERFLOW_LEN   = CAPACITY_DEF + 6;
  localparam int SETTLE_CYCLES  = 4;
  localparam int DRAIN_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam logic [CFG_IDX_BITS-1:0] IDX_UNMAPPED_LO = CFG_IDX_BITS'(NUM_REGS);
  localparam logic [CFG_IDX_BITS-1:0] IDX_UNMAPPED_HI = CFG_IDX_BITS'(NUM_REGS + 1);

  logic                    clk       = 1'b0;
  logic                    rst_n     = 1'b0;
  logic                    start     = 1'b0;
  logic [CHAN_BITS-1:0]    in_blue   = '0;
  logic [CHAN_BITS-1:0]    in_green  = '0;
  logic [CHAN_BITS-1:0]    in_red    = '0;
  logic [COORD_W-1:0]      in_row    = '0;
  logic [COORD_W-1:0]      in_col    = '0;
  logic                    in_last   = 1'b0;
  logic                    cfg_valid = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [CHAN_BITS-1:0]    cfg_data  = '0;

  logic                    busy;
  logic                    out_valid;
  logic [COORD_W-1:0]      out_median_row;
  logic [COORD_W-1:0]      out_median_col;
  logic [TOTAL_BITS-1:0]   out_match_total;
  logic                    out_empty_res;
  logic                    out_overflow;
  logic                    cfg_ready;

  int fail_count;
  int pending;
  int idle_cycles = 0;

  logic [CHAN_BITS-1:0] cur_box  [NUM_REGS];
  logic [CHAN_BITS-1:0] next_box [NUM_REGS];
  bit                   burst;

  always #1 clk = ~clk;

  color_box_median_locator_top u_top (
    .clk, .rst_n, .start, .busy,
    .in_blue, .in_green, .in_red, .in_row, .in_col, .in_last,
    .out_valid, .out_median_row, .out_median_col, .out_match_total,
    .out_empty_res, .out_overflow,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  cbml_median_checker u_checker (
    .clk, .rst_n, .start, .busy,
    .in_blue, .in_green, .in_red, .in_row, .in_col, .in_last,
    .out_valid, .out_median_row, .out_median_col, .out_match_total,
    .out_empty_res, .out_overflow,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .fail_count, .pending
  );

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  task automatic send_pixel(input int b, input int g, input int r, input int row, input int col,
                            input bit last);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start    <= 1'b1;
    in_blue  <= CHAN_BITS'(b);
    in_green <= CHAN_BITS'(g);
    in_red   <= CHAN_BITS'(r);
    in_row   <= COORD_W'(row);
    in_col   <= COORD_W'(col);
    in_last  <= last;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  function automatic int pick_channel(input int ch);
    if ($urandom_range(0, 3) != 0 && cur_box[ch] <= cur_box[ch + 3])
      return $urandom_range(cur_box[ch], cur_box[ch + 3]);
    return $urandom_range(0, 255);
  endfunction

  task automatic send_random_pixel(input bit last, input bit tight);
    int row;
    int col;
    row = tight ? $urandom_range(0, 15) : $urandom_range(0, (1 << COORD_W) - 1);
    col = tight ? $urandom_range(0, 15) : $urandom_range(0, (1 << COORD_W) - 1);
    send_pixel(pick_channel(0), pick_channel(1), pick_channel(2), row, col, last);
  endtask

  task automatic settle();
    start <= 1'b0;
    while (pending != 0 || busy) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_BITS-1:0] idx, input logic [CHAN_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    if (idx < NUM_REGS) cur_box[idx] = data;
  endtask

  task automatic apply_box(input int lb, input int lg, input int lr,
                           input int hb, input int hg, input int hr);
    int i;
    next_box[REG_BLUE_LOW]   = CHAN_BITS'(lb);
    next_box[REG_GREEN_LOW]  = CHAN_BITS'(lg);
    next_box[REG_RED_LOW]    = CHAN_BITS'(lr);
    next_box[REG_BLUE_HIGH]  = CHAN_BITS'(hb);
    next_box[REG_GREEN_HIGH] = CHAN_BITS'(hg);
    next_box[REG_RED_HIGH]   = CHAN_BITS'(hr);
    settle();
    if ($urandom_range(0, 3) == 0)
      cfg_write($urandom_range(0, 1) ? IDX_UNMAPPED_HI : IDX_UNMAPPED_LO,
                CHAN_BITS'($urandom_range(0, 255)));
    for (i = 0; i < NUM_REGS; i++) cfg_write(CFG_IDX_BITS'(i), next_box[i]);
    cfg_valid <= 1'b0;
  endtask

  task automatic apply_random_box();
    int lo [3];
    int hi [3];
    int mode;
    int c;
    mode = $urandom_range(0, 3);
    for (c = 0; c < 3; c++) begin
      case (mode)
        0: begin
          lo[c] = $urandom_range(0, 127);
          hi[c] = $urandom_range(128, 255);
        end
        1: begin
          lo[c] = $urandom_range(0, 255);
          hi[c] = $urandom_range(0, 255);
        end
        2: begin
          lo[c] = 0;
          hi[c] = 255;
        end
        default: begin
          lo[c] = $urandom_range(0, 240);
          hi[c] = lo[c] + $urandom_range(0, 15);
        end
      endcase
    end
    apply_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
  endtask

  initial begin : stimulus
    int n;
    int len;
    int items_sent;
    int frames_sent;
    bit tight;
    for (n = 0; n < NUM_REGS; n++) cur_box[n] = BOX_RESET[n];
    burst = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Default orange box: an empty frame, then the box edges from both sides.
    send_pixel(0, 0, 0, 0, 0, 1'b1);
    send_pixel(50, 122, 230, 8191, 0, 1'b0);
    send_pixel(160, 244, 255, 0, 8191, 1'b0);
    send_pixel(49, 122, 230, 1, 1, 1'b0);
    send_pixel(161, 200, 240, 2, 2, 1'b0);
    send_pixel(100, 121, 240, 3, 3, 1'b0);
    send_pixel(100, 245, 240, 4, 4, 1'b0);
    send_pixel(100, 200, 229, 5, 5, 1'b0);
    send_pixel(100, 200, 255, 4000, 4000, 1'b1);
    send_pixel(100, 200, 240, 10, 20, 1'b0);
    send_pixel(100, 200, 240, 5, 30, 1'b0);
    send_pixel(0, 0, 0, 0, 0, 1'b1);

    apply_box(0, 0, 0, 255, 255, 255);
    send_pixel(0, 0, 0, 0, 0, 1'b0);
    send_pixel(255, 255, 255, 8191, 8191, 1'b1);

    // An inverted box matches nothing.
    apply_box(200, 200, 200, 100, 100, 100);
    send_pixel(150, 150, 150, 1, 1, 1'b0);
    send_pixel(255, 255, 255, 2, 2, 1'b1);

    apply_box(255, 255, 255, 255, 255, 255);
    send_pixel(255, 255, 255, 7, 7, 1'b0);
    send_pixel(254, 255, 255, 8, 8, 1'b1);

    // Writes to unmapped indexes must leave the point box at zero intact.
    apply_box(0, 0, 0, 0, 0, 0);
    send_pixel(0, 0, 0, 9, 9, 1'b1);
    settle();
    cfg_write(IDX_UNMAPPED_LO, 8'hff);
    cfg_write(IDX_UNMAPPED_HI, 8'h00);
    cfg_valid <= 1'b0;
    send_pixel(0, 0, 0, 3, 3, 1'b1);

    // More matches than the stores hold, then a frame that must see the drop flag cleared.
    apply_box(0, 0, 0, 255, 255, 255);
    for (n = 0; n < OVERFLOW_LEN; n++) send_random_pixel(n == OVERFLOW_LEN - 1, n[0]);
    send_random_pixel(1'b1, 1'b0);

    apply_box(BOX_RESET[0], BOX_RESET[1], BOX_RESET[2],
              BOX_RESET[3], BOX_RESET[4], BOX_RESET[5]);
    items_sent  = 0;
    frames_sent = 0;
    while (items_sent < RANDOM_ITEMS || frames_sent < MIN_FRAMES) begin
      if ($urandom_range(0, 5) == 0) apply_random_box();
      else if ($urandom_range(0, 7) == 0) settle();
      burst = ($urandom_range(0, 3) == 0);
      tight = $urandom_range(0, 1);
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 16);
      for (n = 0; n < len; n++) send_random_pixel(n == len - 1, tight);
      items_sent += len;
      frames_sent++;
    end

    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/cbml_pkg.sv
rtl/cbml_cell.sv
rtl/cbml_box.sv
rtl/color_box_median_locator_top.sv
tb/cbml_median_checker.sv
tb/color_box_median_locator_top_tb.sv
